// File: hw/rtl/message_tag_match_engine_defines.svh
// assertion macros for the message tag match engine
// no dependencies; included by modules that carry assertions
`ifndef MESSAGE_TAG_MATCH_ENGINE_DEFINES_SVH
`define MESSAGE_TAG_MATCH_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MTME_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("mtme assertion failed");
`define MTME_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("mtme forbidden condition");
`else
`define MTME_ASSERT(lbl, clk, rstn, prop)
`define MTME_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// File: hw/rtl/mtme_pkg.sv
// shared types and constants of the message tag match engine
// no dependencies
package mtme_pkg;

    localparam int POSTED_DEPTH_DEF = 16;
    localparam int UNEXP_DEPTH_DEF  = 16;
    localparam int HANDLE_BITS_DEF  = 16;
    localparam int ID_BITS          = 32;

    localparam logic [1:0] CMD_POST   = 2'd0;
    localparam logic [1:0] CMD_ARRIVE = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;
    localparam logic [1:0] CMD_RSVD   = 2'd3;

    typedef enum logic [2:0] {
        ST_MATCHED  = 3'd0,
        ST_QUEUED   = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_UNSUP    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    scan_en;
        logic    shift_start;
        logic    shift_en;
        logic    append;
        logic    dec_count;
        logic    res_set;
        status_t res_code;
        logic    out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_post;
        logic is_cancel;
        logic unsup;
        logic hit;
        logic keep;
        logic scan_end;
        logic shift_end;
        logic full;
        logic out_busy;
    } dp_status_t;

endpackage

// File: hw/rtl/mtme_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mtme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic                                re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/mtme_ctrl.sv
// controller state machine of the message tag match engine
// depends on mtme_pkg
module mtme_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  mtme_pkg::dp_status_t    st,
    output mtme_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_APPEND = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_code = mtme_pkg::ST_MATCHED;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (st.unsup) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = mtme_pkg::ST_UNSUP;
                    state_next   = S_DONE;
                end else if (st.hit) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = mtme_pkg::ST_MATCHED;
                    if (st.is_post || st.is_cancel || !st.keep) begin
                        cmd.shift_start = 1'b1;
                        state_next      = S_SHIFT;
                    end else begin
                        state_next = S_DONE;
                    end
                end else if (st.scan_end) begin
                    cmd.res_set = 1'b1;
                    if (st.is_cancel) begin
                        cmd.res_code = mtme_pkg::ST_NOTFOUND;
                        state_next   = S_DONE;
                    end else if (st.full) begin
                        cmd.res_code = mtme_pkg::ST_FULL;
                        state_next   = S_DONE;
                    end else begin
                        cmd.res_code = mtme_pkg::ST_QUEUED;
                        state_next   = S_APPEND;
                    end
                end else begin
                    cmd.scan_en = 1'b1;
                end
            end
            S_SHIFT: begin
                if (st.shift_end) begin
                    cmd.dec_count = 1'b1;
                    state_next    = S_DONE;
                end else begin
                    cmd.shift_en = 1'b1;
                end
            end
            S_APPEND: begin
                cmd.append = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!st.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/mtme_dp.sv
// datapath: item register, posted and unexpected tables, scan and compaction
// depends on mtme_pkg, mtme_ram and the defines header
`include "message_tag_match_engine_defines.svh"
module mtme_dp #(
    parameter int POSTED_DEPTH = mtme_pkg::POSTED_DEPTH_DEF,
    parameter int UNEXP_DEPTH  = mtme_pkg::UNEXP_DEPTH_DEF,
    parameter int HANDLE_BITS  = mtme_pkg::HANDLE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [1:0]                   s_cmd,
    input  logic [mtme_pkg::ID_BITS-1:0] s_tag,
    input  logic [mtme_pkg::ID_BITS-1:0] s_cell_id,
    input  logic [mtme_pkg::ID_BITS-1:0] s_job_id,
    input  logic [mtme_pkg::ID_BITS-1:0] s_proc_id,
    input  logic                         s_persistent,
    input  logic                         s_bad_flags,
    input  logic [HANDLE_BITS-1:0]       s_recv_handle,
    input  logic [HANDLE_BITS-1:0]       s_msg_handle,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [2:0]                   m_status,
    output logic [HANDLE_BITS-1:0]       m_out_recv_handle,
    output logic [HANDLE_BITS-1:0]       m_out_msg_handle,
    output logic [mtme_pkg::ID_BITS-1:0] m_out_tag,
    output logic [mtme_pkg::ID_BITS-1:0] m_out_cell_id,
    output logic [mtme_pkg::ID_BITS-1:0] m_out_job_id,
    output logic [mtme_pkg::ID_BITS-1:0] m_out_proc_id,
    input  mtme_pkg::ctrl_cmd_t          cmd,
    output mtme_pkg::dp_status_t         st
);

    localparam int IDW  = mtme_pkg::ID_BITS;
    localparam int PCW  = $clog2(POSTED_DEPTH + 1);
    localparam int UCW  = $clog2(UNEXP_DEPTH + 1);
    localparam int PAW  = POSTED_DEPTH > 1 ? $clog2(POSTED_DEPTH) : 1;
    localparam int UAW  = UNEXP_DEPTH > 1 ? $clog2(UNEXP_DEPTH) : 1;
    localparam int IW   = PCW > UCW ? PCW : UCW;
    localparam int PW   = 4 * IDW + 1 + HANDLE_BITS;
    localparam int UW   = 4 * IDW + HANDLE_BITS;
    localparam logic [IDW-1:0] ONES = '1;

    // item register
    logic [1:0]             cmd_reg;
    logic [IDW-1:0]         tag_reg, cell_reg, job_reg, proc_reg;
    logic                   pers_reg, bad_reg;
    logic [HANDLE_BITS-1:0] rh_reg, mh_reg;

    logic [PCW-1:0] pcnt_reg;
    logic [UCW-1:0] ucnt_reg;
    logic [IW-1:0]  idx_reg, chk_idx_reg, wr_addr_reg;
    logic           chk_vld_reg, wr_vld_reg;

    logic [PW-1:0] p_rdata;
    logic [UW-1:0] u_rdata;

    logic is_post, is_arrive, is_cancel;
    assign is_post   = (cmd_reg == mtme_pkg::CMD_POST);
    assign is_arrive = (cmd_reg == mtme_pkg::CMD_ARRIVE);
    assign is_cancel = (cmd_reg == mtme_pkg::CMD_CANCEL);

    // posted scan on arrive and cancel, unexpected scan on post
    logic [IW-1:0] scan_cnt;
    assign scan_cnt = is_post ? IW'(ucnt_reg) : IW'(pcnt_reg);
    logic idx_lt;
    assign idx_lt = (idx_reg < scan_cnt);

    // entry fields
    logic [IDW-1:0] e_tag, e_cell, e_job, e_proc;
    logic [HANDLE_BITS-1:0] e_rh, e_body;
    logic e_pers;
    assign e_tag  = is_post ? u_rdata[UW-1 -: IDW] : p_rdata[PW-1 -: IDW];
    assign e_cell = is_post ? u_rdata[UW-IDW-1 -: IDW] : p_rdata[PW-IDW-1 -: IDW];
    assign e_job  = is_post ? u_rdata[UW-2*IDW-1 -: IDW] : p_rdata[PW-2*IDW-1 -: IDW];
    assign e_proc = is_post ? u_rdata[UW-3*IDW-1 -: IDW] : p_rdata[PW-3*IDW-1 -: IDW];
    assign e_body = u_rdata[HANDLE_BITS-1:0];
    assign e_rh   = p_rdata[HANDLE_BITS-1:0];
    assign e_pers = p_rdata[HANDLE_BITS];

    logic match;
    always_comb begin
        if (is_post) begin
            match = (tag_reg == ONES || tag_reg == e_tag)
                 && (cell_reg == ONES || cell_reg == e_cell)
                 && (job_reg == ONES || job_reg == e_job)
                 && (proc_reg == ONES || proc_reg == e_proc);
        end else if (is_arrive) begin
            match = (e_tag == tag_reg)
                 && (e_cell == ONES || e_cell == cell_reg)
                 && (e_job == ONES || e_job == job_reg)
                 && (e_proc == ONES || e_proc == proc_reg);
        end else begin
            match = (e_tag == tag_reg) && (e_cell == cell_reg)
                 && (e_job == job_reg) && (e_proc == proc_reg);
        end
    end

    // ram control
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    assign rd_en   = (cmd.scan_en || cmd.shift_en) && idx_lt;
    assign rd_addr = idx_reg;

    logic p_we, u_we;
    logic [PAW-1:0] p_waddr;
    logic [UAW-1:0] u_waddr;
    logic [PW-1:0]  p_wdata;
    logic [UW-1:0]  u_wdata;

    always_comb begin
        p_we    = 1'b0;
        u_we    = 1'b0;
        p_waddr = wr_addr_reg[PAW-1:0];
        u_waddr = wr_addr_reg[UAW-1:0];
        p_wdata = p_rdata;
        u_wdata = u_rdata;
        if (wr_vld_reg) begin
            p_we = !is_post;
            u_we = is_post;
        end else if (cmd.append) begin
            p_we    = is_post;
            u_we    = is_arrive;
            p_waddr = pcnt_reg[PAW-1:0];
            u_waddr = ucnt_reg[UAW-1:0];
            p_wdata = {tag_reg, cell_reg, job_reg, proc_reg, pers_reg, rh_reg};
            u_wdata = {tag_reg, cell_reg, job_reg, proc_reg, mh_reg};
        end
    end

    mtme_ram #(.WIDTH(PW), .DEPTH(POSTED_DEPTH)) u_posted_ram (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .re    (rd_en && !is_post),
        .raddr (rd_addr[PAW-1:0]),
        .rdata (p_rdata)
    );

    mtme_ram #(.WIDTH(UW), .DEPTH(UNEXP_DEPTH)) u_unexp_ram (
        .aclk  (aclk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (u_wdata),
        .re    (rd_en && is_post),
        .raddr (rd_addr[UAW-1:0]),
        .rdata (u_rdata)
    );

    // item register and scan pointers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg  <= s_cmd;
            tag_reg  <= s_tag;
            cell_reg <= s_cell_id;
            job_reg  <= s_job_id;
            proc_reg <= s_proc_id;
            pers_reg <= s_persistent;
            bad_reg  <= s_bad_flags;
            rh_reg   <= s_recv_handle;
            mh_reg   <= s_msg_handle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            chk_vld_reg <= 1'b0;
            wr_vld_reg  <= 1'b0;
        end else if (cmd.load) begin
            idx_reg     <= '0;
            chk_vld_reg <= 1'b0;
            wr_vld_reg  <= 1'b0;
        end else if (cmd.scan_en) begin
            chk_vld_reg <= idx_lt;
            if (idx_lt) begin
                chk_idx_reg <= idx_reg;
                idx_reg     <= idx_reg + 1'b1;
            end
        end else if (cmd.shift_start) begin
            idx_reg     <= chk_idx_reg + 1'b1;
            chk_vld_reg <= 1'b0;
            wr_vld_reg  <= 1'b0;
        end else if (cmd.shift_en) begin
            wr_vld_reg <= idx_lt;
            if (idx_lt) begin
                wr_addr_reg <= idx_reg - 1'b1;
                idx_reg     <= idx_reg + 1'b1;
            end
        end
    end

    // table fill counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcnt_reg <= '0;
            ucnt_reg <= '0;
        end else if (cmd.append) begin
            if (is_post) begin
                pcnt_reg <= pcnt_reg + 1'b1;
            end else begin
                ucnt_reg <= ucnt_reg + 1'b1;
            end
        end else if (cmd.dec_count) begin
            if (is_post) begin
                ucnt_reg <= ucnt_reg - 1'b1;
            end else begin
                pcnt_reg <= pcnt_reg - 1'b1;
            end
        end
    end

    // result staging and output register
    logic [2:0]             res_status_reg;
    logic [HANDLE_BITS-1:0] res_rh_reg, res_mh_reg;
    logic [IDW-1:0]         res_tag_reg, res_cell_reg, res_job_reg, res_proc_reg;
    logic                   m_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.res_set) begin
            res_status_reg <= cmd.res_code;
            res_rh_reg     <= '0;
            res_mh_reg     <= '0;
            res_tag_reg    <= '0;
            res_cell_reg   <= '0;
            res_job_reg    <= '0;
            res_proc_reg   <= '0;
            if (cmd.res_code == mtme_pkg::ST_MATCHED && !is_cancel) begin
                res_rh_reg   <= is_post ? rh_reg : e_rh;
                res_mh_reg   <= is_post ? e_body : mh_reg;
                res_tag_reg  <= is_post ? e_tag : tag_reg;
                res_cell_reg <= is_post ? e_cell : cell_reg;
                res_job_reg  <= is_post ? e_job : job_reg;
                res_proc_reg <= is_post ? e_proc : proc_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status          <= res_status_reg;
            m_out_recv_handle <= res_rh_reg;
            m_out_msg_handle  <= res_mh_reg;
            m_out_tag         <= res_tag_reg;
            m_out_cell_id     <= res_cell_reg;
            m_out_job_id      <= res_job_reg;
            m_out_proc_id     <= res_proc_reg;
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        st.is_post   = is_post;
        st.is_cancel = is_cancel;
        st.unsup     = (cmd_reg == mtme_pkg::CMD_RSVD) || (is_post && bad_reg);
        st.hit       = chk_vld_reg && match;
        st.keep      = e_pers;
        st.scan_end  = !chk_vld_reg && !idx_lt;
        st.shift_end = !wr_vld_reg && !idx_lt;
        st.full      = is_post ? (pcnt_reg >= PCW'(POSTED_DEPTH))
                               : (ucnt_reg >= UCW'(UNEXP_DEPTH));
        st.out_busy  = m_valid_reg && !m_ready;
    end

    `MTME_NEVER(a_pcnt_range, aclk, aresetn, pcnt_reg > PCW'(POSTED_DEPTH))
    `MTME_NEVER(a_ucnt_range, aclk, aresetn, ucnt_reg > UCW'(UNEXP_DEPTH))
    `MTME_NEVER(a_scan_shift_excl, aclk, aresetn, chk_vld_reg && wr_vld_reg)
    `MTME_ASSERT(a_out_load, aclk, aresetn, cmd.out_load |=> m_valid_reg)

endmodule

// File: hw/rtl/message_tag_match_engine.sv
// top level of the message tag match engine
// depends on mtme_pkg, mtme_ctrl, mtme_dp (and through it mtme_ram)

// Matches arriving messages against posted receives. Two ordered tables live in
// simple dual-port rams: posted receives and unexpected messages, oldest first. A
// post (cmd 0) scans the unexpected table, an arrival (cmd 1) or cancel (cmd 2)
// scans the posted table; a hit is removed by shifting the later entries down
// (a persistent posted receive hit by an arrival stays), and a miss is appended
// to the other table. One item is handled at a time and gives exactly one result
// item. Per item: the item is taken; the scan makes one ram read per cycle,
// compares each read and stops at a hit or at the end of the filled entries; a
// miss is then appended (not when the table is full or a cancel finds nothing);
// removing a hit moves the later entries down one place, reading and writing
// the same ram each cycle; last the result goes to the output register, which
// waits while the previous result is still held there. Unsupported items skip
// the scan. The output register lets a finished result wait while the next item
// is taken. Tables are not cleared at reset; only the fill counts are.
module message_tag_match_engine #(
    parameter int POSTED_DEPTH = mtme_pkg::POSTED_DEPTH_DEF,
    parameter int UNEXP_DEPTH  = mtme_pkg::UNEXP_DEPTH_DEF,
    parameter int HANDLE_BITS  = mtme_pkg::HANDLE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input item channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_cmd,
    input  logic [mtme_pkg::ID_BITS-1:0] s_tag,
    input  logic [mtme_pkg::ID_BITS-1:0] s_cell_id,
    input  logic [mtme_pkg::ID_BITS-1:0] s_job_id,
    input  logic [mtme_pkg::ID_BITS-1:0] s_proc_id,
    input  logic                         s_persistent,
    input  logic                         s_bad_flags,
    input  logic [HANDLE_BITS-1:0]       s_recv_handle,
    input  logic [HANDLE_BITS-1:0]       s_msg_handle,
    // result item channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [2:0]                   m_status,
    output logic [HANDLE_BITS-1:0]       m_out_recv_handle,
    output logic [HANDLE_BITS-1:0]       m_out_msg_handle,
    output logic [mtme_pkg::ID_BITS-1:0] m_out_tag,
    output logic [mtme_pkg::ID_BITS-1:0] m_out_cell_id,
    output logic [mtme_pkg::ID_BITS-1:0] m_out_job_id,
    output logic [mtme_pkg::ID_BITS-1:0] m_out_proc_id
);

    // command and status between the sequencer and the datapath
    mtme_pkg::ctrl_cmd_t  cmd;
    mtme_pkg::dp_status_t st;

    // sequencer: load, scan, shift down or append, then deliver
    mtme_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // tables, compare logic, counts and the output register
    mtme_dp #(
        .POSTED_DEPTH (POSTED_DEPTH),
        .UNEXP_DEPTH  (UNEXP_DEPTH),
        .HANDLE_BITS  (HANDLE_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_cmd             (s_cmd),
        .s_tag             (s_tag),
        .s_cell_id         (s_cell_id),
        .s_job_id          (s_job_id),
        .s_proc_id         (s_proc_id),
        .s_persistent      (s_persistent),
        .s_bad_flags       (s_bad_flags),
        .s_recv_handle     (s_recv_handle),
        .s_msg_handle      (s_msg_handle),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_out_recv_handle (m_out_recv_handle),
        .m_out_msg_handle  (m_out_msg_handle),
        .m_out_tag         (m_out_tag),
        .m_out_cell_id     (m_out_cell_id),
        .m_out_job_id      (m_out_job_id),
        .m_out_proc_id     (m_out_proc_id),
        .cmd               (cmd),
        .st                (st)
    );

endmodule
